@@ rtl/sha256tc_pkg.sv @@
`default_nettype none

package sha256tc_pkg;

    typedef logic [0:7][31:0]  hash_t;
    typedef logic [0:15][31:0] block_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [1:0] LAST_PART     = 2'd3;
    localparam logic [5:0] MAX_ZERO_BYTES = 6'd32;
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [0:0] ADDR_ZERO_BYTES = 1'b0;

    localparam hash_t H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha256_hash_with_target_check_core.sv @@
// A byte that neither completes a 64-byte block nor is the last byte leaves the input unstalled for the next byte.
// A byte that completes a block keeps the input stalled through load, 64 rounds and chain update.
// The last byte adds one or two compressions, each led by a padding or length step,
// then four digest transfers.
// Rounds run one per cycle through a single shared round unit.
// Reset (rst_n low, asynchronous) loads the initial hash, clears the byte count and sets the target to 3.
`default_nettype none

module sha256_hash_with_target_check_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_part,
    output logic             part_last,
    output logic             target_met
);

    sha256tc_pkg::state_t state_reg, state_next;
    sha256tc_pkg::hash_t  chain_reg, chain_next;
    sha256tc_pkg::hash_t  vars_reg, vars_next;
    sha256tc_pkg::block_t block_reg, block_next;
    sha256tc_pkg::block_t win_reg, win_next;
    logic [60:0] total_reg, total_next;
    logic [5:0]  round_reg, round_next;
    logic        last_reg, last_next;
    logic        pad_done_reg, pad_done_next;
    logic        len_done_reg, len_done_next;
    logic [1:0]  part_reg, part_next;
    logic [5:0]  zbn_reg, zbn_next;

    logic        in_take;
    logic        out_take;
    logic        cfg_write;
    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [5:0]  need;
    logic        met;

    assign pos       = total_reg[5:0];
    assign bit_len   = {total_reg, 3'b000};
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        pready   = 1'b1;
        in_stall = (state_reg != sha256tc_pkg::ST_IDLE);
        out_valid = (state_reg == sha256tc_pkg::ST_OUT);
        in_take  = in_valid && !in_stall;
        out_take = out_valid && !out_stall;
        if (paddr[2] == sha256tc_pkg::ADDR_ZERO_BYTES)
        begin
            prdata = {26'b0, zbn_reg};
        end
        else
        begin
            prdata = 32'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha256tc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (pos == sha256tc_pkg::LAST_BYTE_POS)
                    begin
                        state_next = sha256tc_pkg::ST_LOAD;
                    end
                    else if (last_byte)
                    begin
                        state_next = sha256tc_pkg::ST_PAD;
                    end
                end
            end
            sha256tc_pkg::ST_PAD:   state_next = sha256tc_pkg::ST_LOAD;
            sha256tc_pkg::ST_LEN:   state_next = sha256tc_pkg::ST_LOAD;
            sha256tc_pkg::ST_LOAD:  state_next = sha256tc_pkg::ST_ROUND;
            sha256tc_pkg::ST_ROUND:
            begin
                if (round_reg == sha256tc_pkg::LAST_ROUND)
                begin
                    state_next = sha256tc_pkg::ST_UPDATE;
                end
            end
            sha256tc_pkg::ST_UPDATE:
            begin
                if (!last_reg)
                begin
                    state_next = sha256tc_pkg::ST_IDLE;
                end
                else if (!pad_done_reg)
                begin
                    state_next = sha256tc_pkg::ST_PAD;
                end
                else if (!len_done_reg)
                begin
                    state_next = sha256tc_pkg::ST_LEN;
                end
                else
                begin
                    state_next = sha256tc_pkg::ST_OUT;
                end
            end
            sha256tc_pkg::ST_OUT:
            begin
                if (out_take && part_reg == sha256tc_pkg::LAST_PART)
                begin
                    state_next = sha256tc_pkg::ST_IDLE;
                end
            end
            default: state_next = sha256tc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        t1 = vars_reg[7] + sha256tc_pkg::big_sigma1(vars_reg[4])
             + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
             + sha256tc_pkg::ROUND_K[round_reg] + win_reg[0];
        t2 = sha256tc_pkg::big_sigma0(vars_reg[0])
             + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                ^ (vars_reg[1] & vars_reg[2]));
    end

    always_comb
    begin
        logic [5:0] p;
        chain_next    = chain_reg;
        vars_next     = vars_reg;
        block_next    = block_reg;
        win_next      = win_reg;
        total_next    = total_reg;
        round_next    = round_reg;
        last_next     = last_reg;
        pad_done_next = pad_done_reg;
        len_done_next = len_done_reg;
        part_next     = part_reg;
        zbn_next      = zbn_reg;
        p             = 6'd0;

        if (cfg_write && paddr[2] == sha256tc_pkg::ADDR_ZERO_BYTES)
        begin
            zbn_next = pwdata[5:0];
        end

        case (state_reg)
            sha256tc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    block_next[pos[5:2]][(5'd24 - {pos[1:0], 3'b000}) +: 8] = msg_byte;
                    total_next    = total_reg + 61'd1;
                    last_next     = last_byte;
                    pad_done_next = 1'b0;
                    len_done_next = 1'b0;
                end
            end
            sha256tc_pkg::ST_PAD:
            begin
                for (int w = 0; w < 16; w++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        p = 6'(w * 4 + b);
                        if (p == pos)
                        begin
                            block_next[w][31 - 8 * b -: 8] = sha256tc_pkg::PAD_BYTE;
                        end
                        else if (p > pos)
                        begin
                            block_next[w][31 - 8 * b -: 8] = 8'h00;
                        end
                    end
                end
                pad_done_next = 1'b1;
                if (pos < sha256tc_pkg::LEN_FIELD_POS)
                begin
                    block_next[14] = bit_len[63:32];
                    block_next[15] = bit_len[31:0];
                    len_done_next  = 1'b1;
                end
            end
            sha256tc_pkg::ST_LEN:
            begin
                block_next     = '0;
                block_next[14] = bit_len[63:32];
                block_next[15] = bit_len[31:0];
                len_done_next  = 1'b1;
            end
            sha256tc_pkg::ST_LOAD:
            begin
                win_next   = block_reg;
                vars_next  = chain_reg;
                round_next = 6'd0;
            end
            sha256tc_pkg::ST_ROUND:
            begin
                vars_next = {t1 + t2, vars_reg[0], vars_reg[1], vars_reg[2],
                             vars_reg[3] + t1, vars_reg[4], vars_reg[5], vars_reg[6]};
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = sha256tc_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                               + sha256tc_pkg::small_sigma0(win_reg[1]) + win_reg[0];
                round_next = round_reg + 6'd1;
            end
            sha256tc_pkg::ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
            end
            sha256tc_pkg::ST_OUT:
            begin
                if (out_take)
                begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == sha256tc_pkg::LAST_PART)
                    begin
                        chain_next = sha256tc_pkg::H_INIT;
                        total_next = 61'd0;
                        last_next  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        need = (zbn_reg > sha256tc_pkg::MAX_ZERO_BYTES) ? sha256tc_pkg::MAX_ZERO_BYTES : zbn_reg;
        met  = 1'b1;
        for (int k = 0; k < 32; k++)
        begin
            if (6'(k) < need && chain_reg[k / 4][31 - 8 * (k % 4) -: 8] != 8'h00)
            begin
                met = 1'b0;
            end
        end
    end

    assign digest_part = {chain_reg[{part_reg, 1'b0}], chain_reg[{part_reg, 1'b1}]};
    assign part_last   = (part_reg == sha256tc_pkg::LAST_PART);
    assign target_met  = met;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256tc_pkg::ST_IDLE;
            chain_reg    <= sha256tc_pkg::H_INIT;
            total_reg    <= 61'd0;
            round_reg    <= 6'd0;
            last_reg     <= 1'b0;
            pad_done_reg <= 1'b0;
            len_done_reg <= 1'b0;
            part_reg     <= 2'd0;
            zbn_reg      <= 6'd3;
        end
        else
        begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            total_reg    <= total_next;
            round_reg    <= round_next;
            last_reg     <= last_next;
            pad_done_reg <= pad_done_next;
            len_done_reg <= len_done_next;
            part_reg     <= part_next;
            zbn_reg      <= zbn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg  <= vars_next;
        block_reg <= block_next;
        win_reg   <= win_next;
    end

endmodule

`default_nettype wire
